// File: rtl/aavr_pkg.sv
`default_nettype none

package aavr_pkg;

   // Field widths.
   localparam int COORD_WIDTH   = 32;
   localparam int AXIS_W        = 32;
   localparam int ANGLE_W       = 32;

   // CORDIC.
   localparam int CORDIC_STAGES = 30;
   localparam int ANG_ENTRIES   = 40;
   localparam int ITERS         = (CORDIC_STAGES < ANG_ENTRIES) ? CORDIC_STAGES : ANG_ENTRIES;
   localparam int XY_W          = 43;
   localparam int R_W           = 32;
   localparam int CS_SHIFT      = 10;
   localparam int XR_W          = XY_W - CS_SHIFT;

   // Q1.30 arithmetic.
   localparam int Q_SHIFT       = 30;
   localparam int Q_ONE         = 1073741824;
   localparam int C_W           = Q_SHIFT + 2;
   localparam int OMC_W         = C_W + 1;
   localparam int RUV_W         = AXIS_W + COORD_WIDTH - Q_SHIFT;
   localparam int D_W           = RUV_W + 1;
   localparam int W_W           = D_W + 1;
   localparam int A_W           = W_W + 1;
   localparam int T_W           = COORD_WIDTH + 1;
   localparam int Z_W           = D_W;
   localparam int SUM_W         = A_W + 1;
   localparam int PROD_W        = AXIS_W + W_W;

   // Registers after the CORDIC: sine/cosine, products, sums and saturation.
   localparam int POST_STAGES   = 8;
   localparam int LATENCY       = 1 + ITERS + POST_STAGES;

   localparam logic signed [XY_W-1:0] INV_GAIN = 43'sd667681663043;
   localparam logic signed [XY_W-1:0] RND_CS   = XY_W'(1) <<< (CS_SHIFT - 1);
   localparam logic signed [XR_W-1:0] CS_POS   = XR_W'(Q_ONE);
   localparam logic signed [XR_W-1:0] CS_NEG   = -CS_POS;
   localparam logic signed [C_W-1:0]  CQ_POS   = C_W'(Q_ONE);
   localparam logic signed [C_W-1:0]  CQ_NEG   = -CQ_POS;
   localparam logic signed [OMC_W-1:0] OMC_ONE = OMC_W'(Q_ONE);

   localparam logic signed [PROD_W-1:0] RND_POS =
      {{(PROD_W-Q_SHIFT){1'b0}}, 1'b1, {(Q_SHIFT-1){1'b0}}};
   localparam logic signed [PROD_W-1:0] RND_NEG = RND_POS - PROD_W'(1);

   localparam logic signed [SUM_W-1:0] OUT_MAX =
      {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] OUT_MIN = ~OUT_MAX;
   localparam logic [COORD_WIDTH-1:0] ROT_MAX = OUT_MAX[COORD_WIDTH-1:0];
   localparam logic [COORD_WIDTH-1:0] ROT_MIN = OUT_MIN[COORD_WIDTH-1:0];

   // Arctangent of 2^-i in units of 2^-32 turn.
   localparam logic signed [R_W-1:0] ATAN_TAB [ANG_ENTRIES] = '{
      32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
      32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
      32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
      32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
      32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
      32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001,
      32'sh00000001, 32'sh00000000, 32'sh00000000, 32'sh00000000, 32'sh00000000,
      32'sh00000000, 32'sh00000000, 32'sh00000000, 32'sh00000000, 32'sh00000000
   };

   typedef struct packed {
      logic signed [AXIS_W-1:0]      axis_x;
      logic signed [AXIS_W-1:0]      axis_y;
      logic signed [COORD_WIDTH-1:0] vec_x;
      logic signed [COORD_WIDTH-1:0] vec_y;
      logic [ANGLE_W-1:0]            angle;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] rot_x;
      logic signed [COORD_WIDTH-1:0] rot_y;
      logic signed [COORD_WIDTH-1:0] rot_z;
      logic                          saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0]      axis_x;
      logic signed [AXIS_W-1:0]      axis_y;
      logic signed [COORD_WIDTH-1:0] vec_x;
      logic signed [COORD_WIDTH-1:0] vec_y;
      logic                          flip;
   } side_type;

   // Divide by 2^30, rounding to nearest with ties away from zero.
   function automatic logic signed [PROD_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] bias;
      bias = p[PROD_W-1] ? RND_NEG : RND_POS;
      return (p + bias) >>> Q_SHIFT;
   endfunction

   // Clamp a rounded CORDIC output to [-1.0, 1.0] and undo the angle fold.
   function automatic logic signed [C_W-1:0] clamp_cs(input logic signed [XR_W-1:0] v,
                                                       input logic flip);
      logic signed [XR_W-1:0] t;
      logic [C_W-1:0]         m;
      if (v > CS_POS) begin
         t = CS_POS;
      end else if (v < CS_NEG) begin
         t = CS_NEG;
      end else begin
         t = v;
      end
      m = t[C_W-1:0];
      return flip ? -m : m;
   endfunction

   // The top bit flags a clipped value.
   function automatic logic [COORD_WIDTH:0] sat_out(input logic signed [SUM_W-1:0] v);
      logic [COORD_WIDTH:0] r;
      if (v > OUT_MAX) begin
         r = {1'b1, ROT_MAX};
      end else if (v < OUT_MIN) begin
         r = {1'b1, ROT_MIN};
      end else begin
         r = {1'b0, v[COORD_WIDTH-1:0]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/axis_angle_vector_rotation.sv
// Channel   Ports                        Dir  Handshake
// request   start, busy, req_word        in   word taken when start is high and busy is low
// response  rsp_strobe, rsp_word         out  word valid for the one cycle rsp_strobe is high
//
// A word can be taken on every cycle while busy is low; its result passes through one entry
// register, one register per CORDIC stage, then eight registers for sine/cosine rounding,
// the chained Q1.30 products and the output saturation.
// Reset is synchronous and clears only the valid bits; busy is high during reset only.
// The receiver cannot stall, so results leave in order without waiting.
`default_nettype none

module axis_angle_vector_rotation
   import aavr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   // CORDIC line, index 0 is the entry register.
   logic                   cv_ff   [0:ITERS];
   logic signed [XY_W-1:0] cx_ff   [0:ITERS];
   logic signed [XY_W-1:0] cy_ff   [0:ITERS];
   logic signed [R_W-1:0]  rr_ff   [0:ITERS];
   side_type               side_ff [0:ITERS];

   logic                   cv_in;
   logic                   flip_in;
   logic [ANGLE_W-1:0]     fold_in;
   side_type               side_in;

   assign busy = reset;

   always_comb begin
      cv_in   = start && !busy;
      // Angles in the back half-plane are turned by half a turn; the results are negated.
      flip_in = req_word.angle[ANGLE_W-1] ^ req_word.angle[ANGLE_W-2];
      fold_in = {req_word.angle[ANGLE_W-1] ^ flip_in, req_word.angle[ANGLE_W-2:0]};
      side_in.axis_x = req_word.axis_x;
      side_in.axis_y = req_word.axis_y;
      side_in.vec_x  = req_word.vec_x;
      side_in.vec_y  = req_word.vec_y;
      side_in.flip   = flip_in;
   end

   always_ff @(posedge clock) begin
      cx_ff[0]   <= INV_GAIN;
      cy_ff[0]   <= '0;
      rr_ff[0]   <= $signed(fold_in);
      side_ff[0] <= side_in;
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else begin
         cv_ff[0] <= cv_in;
      end
   end

   for (genvar k = 0; k < ITERS; k++) begin : g_cordic
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      logic signed [XY_W-1:0] x_in;
      logic signed [XY_W-1:0] y_in;
      logic signed [R_W-1:0]  r_in;

      always_comb begin
         xs = cx_ff[k] >>> k;
         ys = cy_ff[k] >>> k;
         if (!rr_ff[k][R_W-1]) begin
            x_in = cx_ff[k] - ys;
            y_in = cy_ff[k] + xs;
            r_in = rr_ff[k] - ATAN_TAB[k];
         end else begin
            x_in = cx_ff[k] + ys;
            y_in = cy_ff[k] - xs;
            r_in = rr_ff[k] + ATAN_TAB[k];
         end
      end

      always_ff @(posedge clock) begin
         cx_ff[k+1]   <= x_in;
         cy_ff[k+1]   <= y_in;
         rr_ff[k+1]   <= r_in;
         side_ff[k+1] <= side_ff[k];
         if (reset) begin
            cv_ff[k+1] <= 1'b0;
         end else begin
            cv_ff[k+1] <= cv_ff[k];
         end
      end
   end

   // Post-CORDIC stages.
   logic [POST_STAGES-1:0] pv_ff, pv_in;

   logic signed [XY_W-1:0]              xsum, ysum;
   logic signed [XR_W-1:0]              xr, yr;
   logic signed [C_W-1:0]               c1_ff, c1_in, s1_ff, s1_in;
   side_type                            sd1_ff;
   logic signed [AXIS_W+COORD_WIDTH-1:0] pxx1_ff, pxx1_in, pyy1_ff, pyy1_in;
   logic signed [AXIS_W+COORD_WIDTH-1:0] pxy1_ff, pxy1_in, pyx1_ff, pyx1_in;

   logic signed [PROD_W-1:0]            rnd_xx, rnd_yy, rnd_xy, rnd_yx;
   logic signed [RUV_W-1:0]             qxx2_ff, qxx2_in, qyy2_ff, qyy2_in;
   logic signed [RUV_W-1:0]             qxy2_ff, qxy2_in, qyx2_ff, qyx2_in;
   logic signed [COORD_WIDTH+C_W-1:0]   pvx2_ff, pvx2_in, pvy2_ff, pvy2_in;
   logic signed [OMC_W-1:0]             omc2_ff, omc2_in;
   logic signed [C_W-1:0]               s2_ff;
   logic signed [AXIS_W-1:0]            ux2_ff, uy2_ff;

   logic signed [PROD_W-1:0]            rnd_vx, rnd_vy;
   logic signed [D_W-1:0]               d3_ff, d3_in, cr3_ff, cr3_in;
   logic signed [T_W-1:0]               tx3_ff, tx3_in, ty3_ff, ty3_in;
   logic signed [OMC_W-1:0]             omc3_ff;
   logic signed [C_W-1:0]               s3_ff;
   logic signed [AXIS_W-1:0]            ux3_ff, uy3_ff;

   logic signed [D_W+OMC_W-1:0]         pw4_ff, pw4_in;
   logic signed [D_W+C_W-1:0]           pz4_ff, pz4_in;
   logic signed [T_W-1:0]               tx4_ff, ty4_ff;
   logic signed [AXIS_W-1:0]            ux4_ff, uy4_ff;

   logic signed [PROD_W-1:0]            rnd_w, rnd_z;
   logic signed [W_W-1:0]               w5_ff, w5_in;
   logic signed [Z_W-1:0]               z5_ff, z5_in;
   logic signed [T_W-1:0]               tx5_ff, ty5_ff;
   logic signed [AXIS_W-1:0]            ux5_ff, uy5_ff;

   logic signed [AXIS_W+W_W-1:0]        pax6_ff, pax6_in, pay6_ff, pay6_in;
   logic signed [T_W-1:0]               tx6_ff, ty6_ff;
   logic signed [Z_W-1:0]               z6_ff;

   logic signed [PROD_W-1:0]            rnd_ax, rnd_ay;
   logic signed [A_W-1:0]               ax7_ff, ax7_in, ay7_ff, ay7_in;
   logic signed [T_W-1:0]               tx7_ff, ty7_ff;
   logic signed [Z_W-1:0]               z7_ff;

   logic [COORD_WIDTH:0]                sat_x, sat_y, sat_z;
   rsp_type                             rsp_ff, rsp_in;

   always_comb begin
      pv_in = {pv_ff[POST_STAGES-2:0], cv_ff[ITERS]};

      // Sine and cosine back to Q1.30.
      xsum  = cx_ff[ITERS] + RND_CS;
      ysum  = cy_ff[ITERS] + RND_CS;
      xr    = xsum[XY_W-1:CS_SHIFT];
      yr    = ysum[XY_W-1:CS_SHIFT];
      c1_in = clamp_cs(xr, side_ff[ITERS].flip);
      s1_in = clamp_cs(yr, side_ff[ITERS].flip);
      pxx1_in = $signed(side_ff[ITERS].axis_x) * $signed(side_ff[ITERS].vec_x);
      pyy1_in = $signed(side_ff[ITERS].axis_y) * $signed(side_ff[ITERS].vec_y);
      pxy1_in = $signed(side_ff[ITERS].axis_x) * $signed(side_ff[ITERS].vec_y);
      pyx1_in = $signed(side_ff[ITERS].axis_y) * $signed(side_ff[ITERS].vec_x);

      // Dot and cross terms rounded; v*cos started.
      rnd_xx  = round_q30(PROD_W'(pxx1_ff));
      rnd_yy  = round_q30(PROD_W'(pyy1_ff));
      rnd_xy  = round_q30(PROD_W'(pxy1_ff));
      rnd_yx  = round_q30(PROD_W'(pyx1_ff));
      qxx2_in = rnd_xx[RUV_W-1:0];
      qyy2_in = rnd_yy[RUV_W-1:0];
      qxy2_in = rnd_xy[RUV_W-1:0];
      qyx2_in = rnd_yx[RUV_W-1:0];
      pvx2_in = $signed(sd1_ff.vec_x) * c1_ff;
      pvy2_in = $signed(sd1_ff.vec_y) * c1_ff;
      omc2_in = OMC_ONE - OMC_W'(c1_ff);

      d3_in  = D_W'(qxx2_ff) + D_W'(qyy2_ff);
      cr3_in = D_W'(qxy2_ff) - D_W'(qyx2_ff);
      rnd_vx = round_q30(PROD_W'(pvx2_ff));
      rnd_vy = round_q30(PROD_W'(pvy2_ff));
      tx3_in = rnd_vx[T_W-1:0];
      ty3_in = rnd_vy[T_W-1:0];

      pw4_in = d3_ff * omc3_ff;
      pz4_in = cr3_ff * s3_ff;

      rnd_w = round_q30(PROD_W'(pw4_ff));
      rnd_z = round_q30(PROD_W'(pz4_ff));
      w5_in = rnd_w[W_W-1:0];
      z5_in = rnd_z[Z_W-1:0];

      pax6_in = ux5_ff * w5_ff;
      pay6_in = uy5_ff * w5_ff;

      rnd_ax = round_q30(PROD_W'(pax6_ff));
      rnd_ay = round_q30(PROD_W'(pay6_ff));
      ax7_in = rnd_ax[A_W-1:0];
      ay7_in = rnd_ay[A_W-1:0];

      sat_x = sat_out(SUM_W'(tx7_ff) + SUM_W'(ax7_ff));
      sat_y = sat_out(SUM_W'(ty7_ff) + SUM_W'(ay7_ff));
      sat_z = sat_out(SUM_W'(z7_ff));
      rsp_in.rot_x     = sat_x[COORD_WIDTH-1:0];
      rsp_in.rot_y     = sat_y[COORD_WIDTH-1:0];
      rsp_in.rot_z     = sat_z[COORD_WIDTH-1:0];
      rsp_in.saturated = sat_x[COORD_WIDTH] | sat_y[COORD_WIDTH] | sat_z[COORD_WIDTH];
   end

   always_ff @(posedge clock) begin
      c1_ff   <= c1_in;
      s1_ff   <= s1_in;
      sd1_ff  <= side_ff[ITERS];
      pxx1_ff <= pxx1_in;
      pyy1_ff <= pyy1_in;
      pxy1_ff <= pxy1_in;
      pyx1_ff <= pyx1_in;

      qxx2_ff <= qxx2_in;
      qyy2_ff <= qyy2_in;
      qxy2_ff <= qxy2_in;
      qyx2_ff <= qyx2_in;
      pvx2_ff <= pvx2_in;
      pvy2_ff <= pvy2_in;
      omc2_ff <= omc2_in;
      s2_ff   <= s1_ff;
      ux2_ff  <= sd1_ff.axis_x;
      uy2_ff  <= sd1_ff.axis_y;

      d3_ff   <= d3_in;
      cr3_ff  <= cr3_in;
      tx3_ff  <= tx3_in;
      ty3_ff  <= ty3_in;
      omc3_ff <= omc2_ff;
      s3_ff   <= s2_ff;
      ux3_ff  <= ux2_ff;
      uy3_ff  <= uy2_ff;

      pw4_ff  <= pw4_in;
      pz4_ff  <= pz4_in;
      tx4_ff  <= tx3_ff;
      ty4_ff  <= ty3_ff;
      ux4_ff  <= ux3_ff;
      uy4_ff  <= uy3_ff;

      w5_ff   <= w5_in;
      z5_ff   <= z5_in;
      tx5_ff  <= tx4_ff;
      ty5_ff  <= ty4_ff;
      ux5_ff  <= ux4_ff;
      uy5_ff  <= uy4_ff;

      pax6_ff <= pax6_in;
      pay6_ff <= pay6_in;
      tx6_ff  <= tx5_ff;
      ty6_ff  <= ty5_ff;
      z6_ff   <= z5_ff;

      ax7_ff  <= ax7_in;
      ay7_ff  <= ay7_in;
      tx7_ff  <= tx6_ff;
      ty7_ff  <= ty6_ff;
      z7_ff   <= z6_ff;

      rsp_ff  <= rsp_in;

      if (reset) begin
         pv_ff <= '0;
      end else begin
         pv_ff <= pv_in;
      end
   end

   assign rsp_strobe = pv_ff[POST_STAGES-1];
   assign rsp_word   = rsp_ff;

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result word without a matching request word");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("request word produced no result word");

   a_sat_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.saturated) |->
         (rsp_word.rot_x == ROT_MAX || rsp_word.rot_x == ROT_MIN ||
          rsp_word.rot_y == ROT_MAX || rsp_word.rot_y == ROT_MIN ||
          rsp_word.rot_z == ROT_MAX || rsp_word.rot_z == ROT_MIN))
      else $error("saturation flag set with no component at a limit");

   a_cs_range: assert property (@(posedge clock) disable iff (reset)
      pv_ff[0] |-> (c1_ff <= CQ_POS && c1_ff >= CQ_NEG && s1_ff <= CQ_POS && s1_ff >= CQ_NEG))
      else $error("sine or cosine outside the unit range");

   a_omc_sign: assert property (@(posedge clock) disable iff (reset)
      pv_ff[1] |-> !omc2_ff[OMC_W-1])
      else $error("one minus cosine went negative");

endmodule

`default_nettype wire
